@@ rtl/pts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg: shared types for the priority task scheduler
// Command codes, field widths, the cell control bundle and the scan token.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned IDX_W   = 3;   // task index, up to 8 tasks
  localparam int unsigned PRIO_W  = 4;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned TABLE_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_BLOCK = 2'd1,
    CMD_SCHED = 2'd2
  } cmd_e;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic              tick;       // advance: compare wake tick against cnt_next
    logic              block;      // block the running task
    logic [IDX_W-1:0]  running;    // running task index
    logic [TICK_W-1:0] cnt_next;   // tick count after the advance
    logic [TICK_W-1:0] wake;       // wake tick for a block
  } cell_ctrl_t;

  // Token that walks the cell row during a schedule.
  // ref_prio has one extra bit: 5'h10 accepts the first ready task.
  typedef struct packed {
    logic              valid;
    logic [PRIO_W:0]   ref_prio;
    logic [IDX_W-1:0]  best;
    logic              any;
  } scan_t;

endpackage

@@ rtl/pts_cmd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_cmd_if: command channel
// valid/ready handshake carrying one scheduler command per beat.
// ----------------------------------------------------------------------------
interface pts_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [pts_pkg::CMD_W-1:0]         command;
  logic [pts_pkg::TICK_W-1:0]        delay_ticks;

  modport source (output valid, output command, output delay_ticks, input ready);
  modport sink   (input valid, input command, input delay_ticks, output ready);
endinterface

@@ rtl/pts_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_rsp_if: result channel
// valid/ready handshake carrying the scheduler state after each command.
// ----------------------------------------------------------------------------
interface pts_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [pts_pkg::IDX_W-1:0]         current_index;
  logic [pts_pkg::MASK_W-1:0]        blocked_mask;
  logic [pts_pkg::TICK_W-1:0]        tick_now;

  modport source (output valid, output current_index, output blocked_mask,
                  output tick_now, input ready);
  modport sink   (input valid, input current_index, input blocked_mask,
                  input tick_now, output ready);
endinterface

@@ rtl/pts_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_cell: one task slot of the scheduler row
// Holds the blocked flag and wake tick of one task and advances the
// schedule token by one slot per cycle.
// ----------------------------------------------------------------------------
module pts_cell #(
  parameter logic [2:0] CELL_IDX = 3'd1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pts_pkg::cell_ctrl_t           ctrl_i,
  input  logic [pts_pkg::PRIO_W-1:0]    prio_i,
  input  pts_pkg::scan_t                scan_i,
  output pts_pkg::scan_t                scan_o,
  output logic                          blocked_o
);
  import pts_pkg::*;

  logic              blocked_q, blocked_d;
  logic [TICK_W-1:0] wake_q;
  scan_t             scan_q, scan_d;
  logic              take;

  always_comb begin
    blocked_d = blocked_q;
    if (ctrl_i.tick && blocked_q && (wake_q == ctrl_i.cnt_next)) begin
      blocked_d = 1'b0;
    end else if (ctrl_i.block && (ctrl_i.running == CELL_IDX)) begin
      blocked_d = 1'b1;
    end
  end

  // ready task at or below the reference wins; later index wins a tie
  assign take = !blocked_q && ({1'b0, prio_i} <= scan_i.ref_prio);

  always_comb begin
    scan_d          = scan_i;
    scan_d.any      = scan_i.any | !blocked_q;
    if (take) begin
      scan_d.ref_prio = {1'b0, prio_i};
      scan_d.best     = CELL_IDX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocked_q <= 1'b0;
      scan_q    <= '0;
    end else begin
      blocked_q <= blocked_d;
      scan_q    <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.block && (ctrl_i.running == CELL_IDX)) begin
      wake_q <= ctrl_i.wake;
    end
  end

  assign scan_o    = scan_q;
  assign blocked_o = blocked_q;

endmodule

@@ rtl/priority_task_scheduler_with_delay.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_scheduler_with_delay: tick-driven priority task scheduler
// Row of task cells (tasks 1..TASK_COUNT-1, task 0 is idle) with a small
// sequencer, tick counter, running index and a registered result stage.
// ----------------------------------------------------------------------------
//
//  channel      dir  handshake        payload
//  -----------  ---  ---------------  -----------------------------------
//  cmd_i        in   valid/ready      command, delay_ticks
//  rsp_o        out  valid/ready      current_index, blocked_mask, tick_now
//  cfg_we_i     in   write enable     cfg_wdata_i -> priority table
//
//  Tick, block and unused command: the accept updates, then the result state
//  loads the result. Schedule: the accept launches the token, it walks one
//  cell per cycle through TASK_COUNT-1 cells, then the result state loads
//  the result.
//  Reset clears tick count, running index and all blocked flags.
//  A new command is taken only in idle, when the result slot is empty or
//  draining in the same cycle; a stalled result holds.
// ----------------------------------------------------------------------------
module priority_task_scheduler_with_delay #(
  parameter int unsigned TASK_COUNT = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pts_pkg::TABLE_W-1:0]   cfg_wdata_i,
  pts_cmd_if.sink                       cmd_i,
  pts_rsp_if.source                     rsp_o
);
  import pts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_RESULT = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [TABLE_W-1:0] prio_table_q;
  logic [TICK_W-1:0]  tick_q, tick_d;
  logic [IDX_W-1:0]   running_q, running_d;

  logic               out_valid_q;
  logic [IDX_W-1:0]   out_idx_q;
  logic [MASK_W-1:0]  out_mask_q;
  logic [TICK_W-1:0]  out_tick_q;

  logic               accept;
  cmd_e               cmd;
  cell_ctrl_t         ctrl;
  logic [MASK_W-1:0]  blocked_w;
  scan_t              scan_head;
  scan_t              chain [TASK_COUNT];
  scan_t              scan_last;
  logic [PRIO_W-1:0]  cur_prio;

  // --------------------------------------------------------------------------
  // Input handshake
  // --------------------------------------------------------------------------
  assign cmd_i.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign cmd         = cmd_e'(cmd_i.command);

  // Cell broadcast: tick and block act on the accept edge.
  always_comb begin
    ctrl          = '0;
    ctrl.tick     = accept && (cmd == CMD_TICK);
    ctrl.block    = accept && (cmd == CMD_BLOCK);
    ctrl.running  = running_q;
    ctrl.cnt_next = tick_q + TICK_W'(1);
    ctrl.wake     = tick_q + cmd_i.delay_ticks;
  end

  // --------------------------------------------------------------------------
  // Scan token launch. A blocked running task makes the first ready task the
  // reference, which is the same as accepting the first ready one outright.
  // --------------------------------------------------------------------------
  assign cur_prio = prio_table_q[{running_q, 2'b00} +: PRIO_W];

  always_comb begin
    scan_head          = '0;
    scan_head.valid    = accept && (cmd == CMD_SCHED);
    scan_head.ref_prio = blocked_w[running_q] ? {1'b1, {PRIO_W{1'b0}}}
                                              : {1'b0, cur_prio};
    scan_head.best     = running_q;
    scan_head.any      = 1'b0;
  end

  assign chain[0] = scan_head;

  // --------------------------------------------------------------------------
  // Cell row
  // --------------------------------------------------------------------------
  assign blocked_w[0] = 1'b0;   // idle task never blocks

  for (genvar k = 1; k < MASK_W; k++) begin : g_slot
    if (k < TASK_COUNT) begin : g_cell
      pts_cell #(
        .CELL_IDX (IDX_W'(k))
      ) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (ctrl),
        .prio_i    (prio_table_q[k*PRIO_W +: PRIO_W]),
        .scan_i    (chain[k-1]),
        .scan_o    (chain[k]),
        .blocked_o (blocked_w[k])
      );
    end else begin : g_none
      assign blocked_w[k] = 1'b0;
    end
  end

  assign scan_last = chain[TASK_COUNT-1];

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    tick_d    = tick_q;
    running_d = running_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd == CMD_TICK) begin
            tick_d = ctrl.cnt_next;
          end
          state_d = (cmd == CMD_SCHED) ? ST_SCAN : ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (scan_last.valid) begin
          running_d = scan_last.any ? scan_last.best : '0;
          state_d   = ST_RESULT;
        end
      end
      ST_RESULT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tick_q       <= '0;
      running_q    <= '0;
      prio_table_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      tick_q    <= tick_d;
      running_q <= running_d;
      if (cfg_we_i) begin
        prio_table_q <= cfg_wdata_i;
      end
      if (state_q == ST_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded from settled state
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RESULT) begin
      out_idx_q  <= running_q;
      out_mask_q <= blocked_w;
      out_tick_q <= tick_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.current_index = out_idx_q;
  assign rsp_o.blocked_mask  = out_mask_q;
  assign rsp_o.tick_now      = out_tick_q;

`ifndef SYNTHESIS
  // result load never lands on an undrained beat
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT) |-> !out_valid_q)
    else $error("result load over pending beat");

  // token leaves the row only while the sequencer waits for it
  a_scan_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_last.valid |-> (state_q == ST_SCAN))
    else $error("scan token outside scan state");

  // running index stays inside the task table
  a_run_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(running_q) < TASK_COUNT)
    else $error("running index out of range");

  // a scheduled task is ready when picked
  a_pick_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && scan_last.valid) |=> !blocked_w[running_q])
    else $error("scheduled task is blocked");
`endif

endmodule
